// ----- hdl/bsfd_pkg.sv -----
// ----------------------------------------------------------------------------
// bsfd_pkg
// Types, constants and register codes shared by the sensor fault detector.
// ----------------------------------------------------------------------------
package bsfd_pkg;

   localparam int MUL_W      = 34;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int DIV_NUM_W  = 68;
   localparam int DIV_DEN_W  = 52;
   localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);
   localparam int CSR_ADDR_W = 4;

   localparam logic [30:0] E1_Q32        = 31'd1580030169;
   localparam logic [19:0] EXP_LIMIT_Q16 = 20'd786432;
   localparam logic [3:0]  TAYLOR_TERMS  = 4'd10;
   localparam logic [32:0] ONE_Q32       = 33'h1_0000_0000;

   localparam logic [15:0] NORMAL_SIGMA_RST    = 16'd256;
   localparam logic [15:0] FAULT_SIGMA_RST     = 16'd2560;
   localparam logic [15:0] PRIOR_FAULT_RST     = 16'd655;
   localparam logic [15:0] FAULT_THRESHOLD_RST = 16'd62259;

   typedef enum logic [1:0] {
      REG_NORMAL_SIGMA    = 2'd0,
      REG_FAULT_SIGMA     = 2'd1,
      REG_PRIOR_FAULT     = 2'd2,
      REG_FAULT_THRESHOLD = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [15:0] normal_sigma;
      logic [15:0] fault_sigma;
      logic [15:0] prior_fault;
      logic [15:0] fault_threshold;
      logic        prior_load;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MSQ,
      ST_SSQ,
      ST_XDIV,
      ST_TMUL,
      ST_TDIV,
      ST_KMUL,
      ST_A0A,
      ST_A0B,
      ST_A1A,
      ST_A1B,
      ST_QDIV,
      ST_DONE
   } state_type;

endpackage

// ----- hdl/bsfd_if.sv -----
// ----------------------------------------------------------------------------
// bsfd_req_if / bsfd_rsp_if
// Valid/ready channels carrying measurements in and posteriors out.
// ----------------------------------------------------------------------------
interface bsfd_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] measurement;

   modport source (output valid, output measurement, input ready);
   modport sink   (input valid, input measurement, output ready);
endinterface

interface bsfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] posterior;
   logic        evidence_underflow;
   logic        fault_detected;

   modport source (output valid, output posterior, output evidence_underflow,
                   output fault_detected, input ready);
   modport sink   (input valid, input posterior, input evidence_underflow,
                   input fault_detected, output ready);
endinterface

// ----- hdl/bsfd_csr.sv -----
// ----------------------------------------------------------------------------
// bsfd_csr
// APB-style register file for sigmas, prior and threshold.
// ----------------------------------------------------------------------------
module bsfd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bsfd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready,
   output bsfd_pkg::cfg_type                  cfg
);
   import bsfd_pkg::*;

   logic [15:0]   normal_sigma_ff, fault_sigma_ff, prior_fault_ff, fault_threshold_ff;
   logic          wr_en;
   reg_index_type idx;

   assign idx        = reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         normal_sigma_ff    <= NORMAL_SIGMA_RST;
         fault_sigma_ff     <= FAULT_SIGMA_RST;
         prior_fault_ff     <= PRIOR_FAULT_RST;
         fault_threshold_ff <= FAULT_THRESHOLD_RST;
      end else if (wr_en) begin
         unique case (idx)
            REG_NORMAL_SIGMA:    normal_sigma_ff    <= csr_pwdata[15:0];
            REG_FAULT_SIGMA:     fault_sigma_ff     <= csr_pwdata[15:0];
            REG_PRIOR_FAULT:     prior_fault_ff     <= csr_pwdata[15:0];
            REG_FAULT_THRESHOLD: fault_threshold_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_NORMAL_SIGMA:    csr_prdata = {16'd0, normal_sigma_ff};
         REG_FAULT_SIGMA:     csr_prdata = {16'd0, fault_sigma_ff};
         REG_PRIOR_FAULT:     csr_prdata = {16'd0, prior_fault_ff};
         REG_FAULT_THRESHOLD: csr_prdata = {16'd0, fault_threshold_ff};
         default:             csr_prdata = 32'd0;
      endcase
   end

   assign cfg.normal_sigma    = normal_sigma_ff;
   assign cfg.fault_sigma     = fault_sigma_ff;
   assign cfg.prior_fault     = prior_fault_ff;
   assign cfg.fault_threshold = fault_threshold_ff;
   assign cfg.prior_load      = wr_en && (idx == REG_PRIOR_FAULT);

endmodule

// ----- hdl/bsfd_mul.sv -----
// ----------------------------------------------------------------------------
// bsfd_mul
// Bit-serial shift-add multiplier; one multiplier bit per cycle, stops early
// once the remaining multiplier bits are all zero.
// ----------------------------------------------------------------------------
module bsfd_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bsfd_pkg::MUL_W-1:0]   a,
   input  logic [bsfd_pkg::MUL_W-1:0]   b,
   output logic                         done,
   output logic [bsfd_pkg::PROD_W-1:0]  prod
);
   import bsfd_pkg::*;

   logic              busy_ff;
   logic [PROD_W-1:0] a_ff, acc_ff;
   logic [MUL_W-1:0]  b_ff;

   assign done = busy_ff && (b_ff == '0);
   assign prod = acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (done) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= {{(PROD_W-MUL_W){1'b0}}, a};
         b_ff   <= b;
         acc_ff <= '0;
      end else if (busy_ff && (b_ff != '0)) begin
         if (b_ff[0]) begin
            acc_ff <= acc_ff + a_ff;
         end
         a_ff <= {a_ff[PROD_W-2:0], 1'b0};
         b_ff <= {1'b0, b_ff[MUL_W-1:1]};
      end
   end

endmodule

// ----- hdl/bsfd_div.sv -----
// ----------------------------------------------------------------------------
// bsfd_div
// Restoring radix-2 divider; one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bsfd_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [bsfd_pkg::DIV_NUM_W-1:0]  num,
   input  logic [bsfd_pkg::DIV_DEN_W-1:0]  den,
   output logic                            done,
   output logic [bsfd_pkg::DIV_NUM_W-1:0]  quot
);
   import bsfd_pkg::*;

   logic                 busy_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_NUM_W-1:0] num_ff, quot_ff;
   logic [DIV_DEN_W-1:0] den_ff, rem_ff;
   logic [DIV_DEN_W:0]   rem_sh;
   logic                 fits;

   assign done   = busy_ff && (cnt_ff == '0);
   assign quot   = quot_ff;
   assign rem_sh = {rem_ff, num_ff[DIV_NUM_W-1]};
   assign fits   = rem_sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (done) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff  <= num;
         den_ff  <= den;
         rem_ff  <= '0;
         quot_ff <= '0;
         cnt_ff  <= DIV_CNT_W'(DIV_NUM_W);
      end else if (busy_ff && (cnt_ff != '0)) begin
         if (fits) begin
            rem_ff <= DIV_DEN_W'(rem_sh - {1'b0, den_ff});
         end else begin
            rem_ff <= rem_sh[DIV_DEN_W-1:0];
         end
         quot_ff <= {quot_ff[DIV_NUM_W-2:0], fits};
         num_ff  <= {num_ff[DIV_NUM_W-2:0], 1'b0};
         cnt_ff  <= cnt_ff - 1'b1;
      end
   end

endmodule

// ----- hdl/bayesian_sensor_fault_detector.sv -----
// ----------------------------------------------------------------------------
// bayesian_sensor_fault_detector
// Sequential two-hypothesis Bayesian test on signed Q8.8 sensor residuals.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one signed Q8.8 measurement per item; rsp_if returns one
//   item per measurement: Q0.16 posterior, evidence underflow and fault flag.
//   The csr_ port holds the two sigmas, the prior and the threshold; writing
//   the prior also reloads the stored fault probability.
// Timing:
//   One item at a time, through one bit-serial multiplier and one restoring
//   divider shared by all steps. Each division holds the sequencer until all
//   quotient bits are done, each multiply until its remaining multiplier bits
//   are zero. Per item: two exponent divisions, per hypothesis ten series
//   steps of a multiply and a division and up to 11 rounding multiplies, four
//   scaling multiplies and the final division; the series and rounding steps
//   are skipped for an exponent that saturates. The next item can be taken in
//   the cycle after the result is written out.
// Reset:
//   Registers return to their defaults and the fault probability to the prior.
// Stall:
//   A finished item waits in the output register; the next measurement is
//   taken meanwhile, and its result is held until the receiver takes the first.
// ----------------------------------------------------------------------------
module bayesian_sensor_fault_detector (
   input  logic                             clock,
   input  logic                             reset,
   bsfd_req_if.sink                         req_if,
   bsfd_rsp_if.source                       rsp_if,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [bsfd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   import bsfd_pkg::*;

   cfg_type   cfg;
   state_type state_ff, state_in;
   logic      issued_ff, issued_in;
   logic      mul_start, mul_done, div_start, div_done;
   logic [MUL_W-1:0]     mul_a, mul_b;
   logic [PROD_W-1:0]    prod;
   logic [DIV_NUM_W-1:0] div_num, quot;
   logic [DIV_DEN_W-1:0] div_den;

   logic [15:0] fault_prob_ff;
   logic [15:0] mag_ff, s0_ff, s1_ff;
   logic        hyp_ff;
   logic [31:0] msq_ff, s2_ff;
   logic [3:0]  k_ff, n_ff;
   logic [15:0] f_ff;
   logic [32:0] r_ff, t_ff;
   logic [16:0] e0_ff, e1_ff;
   logic [49:0] a0_ff, a1_ff;
   logic [15:0] post_ff;
   logic        uf_ff;
   logic        rsp_valid_ff;
   logic [15:0] rsp_post_ff;
   logic        rsp_uf_ff, rsp_fault_ff;

   logic [15:0] s_cur;
   logic [50:0] sum;
   logic        x_big;
   logic [32:0] r_round;
   logic [16:0] e_round;
   logic [18:0] q_inc;
   logic [15:0] q_post;
   logic        accept, out_free;

   bsfd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bsfd_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (prod)
   );

   bsfd_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (quot)
   );

   assign accept   = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE);

   assign s_cur   = hyp_ff ? s1_ff : s0_ff;
   assign sum     = {1'b0, a0_ff} + {1'b0, a1_ff};
   assign x_big   = (quot[DIV_NUM_W-1:20] != '0) || (quot[19:0] >= EXP_LIMIT_Q16);
   assign r_round = prod[64:32] + {32'd0, prod[31]};
   assign e_round = 17'((r_ff + 33'd32768) >> 16);
   assign q_inc   = {1'b0, quot[17:0]} + 19'd1;
   assign q_post  = (q_inc[18:17] != 2'b00) ? 16'hFFFF : q_inc[16:1];

   // operand selection for the shared units
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      div_num = '0;
      div_den = '0;
      unique case (state_ff)
         ST_MSQ: begin
            mul_a = MUL_W'(mag_ff);
            mul_b = MUL_W'(mag_ff);
         end
         ST_SSQ: begin
            mul_a = MUL_W'(s_cur);
            mul_b = MUL_W'(s_cur);
         end
         ST_TMUL: begin
            mul_a = MUL_W'(r_ff);
            mul_b = MUL_W'(f_ff);
         end
         ST_KMUL: begin
            mul_a = MUL_W'(r_ff);
            mul_b = MUL_W'(E1_Q32);
         end
         ST_A0A: begin
            mul_a = MUL_W'(e0_ff);
            mul_b = MUL_W'(s1_ff);
         end
         ST_A0B: begin
            mul_a = MUL_W'(t_ff);
            mul_b = MUL_W'(17'h10000 - {1'b0, fault_prob_ff});
         end
         ST_A1A: begin
            mul_a = MUL_W'(e1_ff);
            mul_b = MUL_W'(s0_ff);
         end
         ST_A1B: begin
            mul_a = MUL_W'(t_ff);
            mul_b = MUL_W'(fault_prob_ff);
         end
         ST_XDIV: begin
            div_num = DIV_NUM_W'({msq_ff, 16'd0} + {16'd0, s2_ff});
            div_den = DIV_DEN_W'({s2_ff, 1'b0});
         end
         ST_TDIV: begin
            div_num = DIV_NUM_W'(t_ff[31:0]);
            div_den = DIV_DEN_W'(n_ff);
         end
         ST_QDIV: begin
            div_num = DIV_NUM_W'({a1_ff, 17'd0});
            div_den = DIV_DEN_W'(sum);
         end
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      issued_in = issued_ff;
      mul_start = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MSQ;
            end
         end
         ST_MSQ, ST_SSQ, ST_TMUL, ST_A0A, ST_A0B, ST_A1A, ST_A1B: begin
            if (!issued_ff) begin
               mul_start = 1'b1;
               issued_in = 1'b1;
            end else if (mul_done) begin
               issued_in = 1'b0;
               unique case (state_ff)
                  ST_MSQ:  state_in = ST_SSQ;
                  ST_SSQ:  state_in = ST_XDIV;
                  ST_TMUL: state_in = ST_TDIV;
                  ST_A0A:  state_in = ST_A0B;
                  ST_A0B:  state_in = ST_A1A;
                  ST_A1A:  state_in = ST_A1B;
                  default: state_in = ST_QDIV;
               endcase
            end
         end
         ST_XDIV: begin
            if (!issued_ff) begin
               div_start = 1'b1;
               issued_in = 1'b1;
            end else if (div_done) begin
               issued_in = 1'b0;
               if (!x_big) begin
                  state_in = ST_TMUL;
               end else if (!hyp_ff) begin
                  state_in = ST_SSQ;
               end else begin
                  state_in = ST_A0A;
               end
            end
         end
         ST_TDIV: begin
            if (!issued_ff) begin
               div_start = 1'b1;
               issued_in = 1'b1;
            end else if (div_done) begin
               issued_in = 1'b0;
               state_in  = (n_ff == 4'd1) ? ST_KMUL : ST_TMUL;
            end
         end
         ST_KMUL: begin
            if (!issued_ff) begin
               if (k_ff == 4'd0) begin
                  state_in = hyp_ff ? ST_A0A : ST_SSQ;
               end else begin
                  mul_start = 1'b1;
                  issued_in = 1'b1;
               end
            end else if (mul_done) begin
               issued_in = 1'b0;
            end
         end
         ST_QDIV: begin
            if (!issued_ff) begin
               if (sum == '0) begin
                  state_in = ST_DONE;
               end else begin
                  div_start = 1'b1;
                  issued_in = 1'b1;
               end
            end else if (div_done) begin
               issued_in = 1'b0;
               state_in  = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in  = ST_IDLE;
            issued_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         issued_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         issued_ff <= issued_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         mag_ff <= req_if.measurement[15] ? 16'(-req_if.measurement) : req_if.measurement;
         s0_ff  <= (cfg.normal_sigma == 16'd0) ? 16'd1 : cfg.normal_sigma;
         s1_ff  <= (cfg.fault_sigma == 16'd0) ? 16'd1 : cfg.fault_sigma;
         hyp_ff <= 1'b0;
      end
      if (issued_ff && mul_done) begin
         unique case (state_ff)
            ST_MSQ:  msq_ff <= prod[31:0];
            ST_SSQ:  s2_ff  <= prod[31:0];
            ST_TMUL: t_ff   <= {1'b0, prod[47:16]};
            ST_KMUL: begin
               r_ff <= r_round;
               k_ff <= k_ff - 4'd1;
            end
            ST_A0A:  t_ff   <= prod[32:0];
            ST_A0B:  a0_ff  <= prod[49:0];
            ST_A1A:  t_ff   <= prod[32:0];
            ST_A1B:  a1_ff  <= prod[49:0];
            default: ;
         endcase
      end
      if (issued_ff && div_done) begin
         unique case (state_ff)
            ST_XDIV: begin
               if (x_big) begin
                  if (hyp_ff) begin
                     e1_ff <= '0;
                  end else begin
                     e0_ff <= '0;
                  end
                  hyp_ff <= 1'b1;
               end else begin
                  k_ff <= quot[19:16];
                  f_ff <= quot[15:0];
                  r_ff <= ONE_Q32;
                  n_ff <= TAYLOR_TERMS;
               end
            end
            ST_TDIV: begin
               r_ff <= ONE_Q32 - quot[32:0];
               n_ff <= n_ff - 4'd1;
            end
            ST_QDIV: begin
               post_ff <= q_post;
               uf_ff   <= 1'b0;
            end
            default: ;
         endcase
      end
      // exponent finished: store the likelihood; after the normal sigma, move to the fault sigma
      if ((state_ff == ST_KMUL) && !issued_ff && (k_ff == 4'd0)) begin
         if (hyp_ff) begin
            e1_ff <= e_round;
         end else begin
            e0_ff <= e_round;
         end
         hyp_ff <= 1'b1;
      end
      if ((state_ff == ST_QDIV) && !issued_ff && (sum == '0)) begin
         post_ff <= fault_prob_ff;
         uf_ff   <= 1'b1;
      end
   end

   // stored probability and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         fault_prob_ff <= PRIOR_FAULT_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cfg.prior_load) begin
            fault_prob_ff <= csr_pwdata[15:0];
         end else if ((state_ff == ST_DONE) && out_free && !uf_ff) begin
            fault_prob_ff <= post_ff;
         end
         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_post_ff  <= post_ff;
         rsp_uf_ff    <= uf_ff;
         rsp_fault_ff <= (post_ff >= cfg.fault_threshold);
      end
   end

   assign rsp_if.valid              = rsp_valid_ff;
   assign rsp_if.posterior          = rsp_post_ff;
   assign rsp_if.evidence_underflow = rsp_uf_ff;
   assign rsp_if.fault_detected     = rsp_fault_ff;

endmodule

// ----- tb/sv/tb_bayesian_sensor_fault_detector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bayesian_sensor_fault_detector
// Drives measurements through the fault detector while the result side
// stalls, and checks every posterior, underflow and fault flag against a
// bit-true fixed-point Bayes update kept in the bench. The sigmas, prior and
// threshold are reprogrammed between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_bayesian_sensor_fault_detector;
   import bsfd_pkg::*;

   localparam longint CYCLE_LIMIT = 12_000_000;
   localparam int     LONG_HOLD   = 8000;
   localparam int     RAND_PHASES = 8;
   localparam int     PHASE_ITEMS = 125;

   typedef struct {
      logic [15:0] posterior;
      logic        underflow;
      logic        fault;
   } verdict_type;

   typedef struct {
      bit            is_csr;
      reg_index_type idx;
      logic [15:0]   value;
      bit            typed;
      verdict_type   want;
   } dir_row_type;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   bsfd_req_if req ();
   bsfd_rsp_if rsp ();

   bayesian_sensor_fault_detector u_top (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req),
      .rsp_if      (rsp),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // bench copy of the registers and the stored probability
   logic [15:0]  sig_normal, sig_fault, prior_val, thresh_val, fault_prob;
   verdict_type  expected_verdicts[$];
   dir_row_type  dir_table[$];
   int           mismatches;
   longint       cycles;
   logic         hold_kick;
   int           hold_left;
   int           stall_mode;
   int           mode_left;

   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_bayesian_sensor_fault_detector failed");
         $finish;
      end
   end

   function automatic logic [63:0] exp_neg(logic [63:0] x);
      logic [63:0] r, f, k;
      if (x >= 64'(EXP_LIMIT_Q16)) return 64'd0;
      k = x >> 16;
      f = x & 64'hFFFF;
      r = 64'(ONE_Q32);
      for (int n = int'(TAYLOR_TERMS); n >= 1; n--)
         r = 64'(ONE_Q32) - ((f * r) >> 16) / 64'(n);
      for (longint i = 0; i < longint'(k); i++)
         r = (r * 64'(E1_Q32) + 64'h8000_0000) >> 32;
      return (r + 64'h8000) >> 16;
   endfunction

   function automatic logic [63:0] likelihood(logic [63:0] mag, logic [63:0] s);
      logic [63:0] s2, x;
      s2 = s * s;
      x  = ((mag * mag) << 16) + s2;
      return exp_neg(x / (2 * s2));
   endfunction

   // one Bayes step on the bench state
   function automatic verdict_type bayes_update(logic signed [15:0] m);
      verdict_type v;
      logic [63:0] mag, s0, s1, p, a0, a1, total, q, rem, post;
      mag = (m < 0) ? 64'(-int'(m)) : 64'(m);
      s0  = (sig_normal == 0) ? 64'd1 : 64'(sig_normal);
      s1  = (sig_fault == 0) ? 64'd1 : 64'(sig_fault);
      p   = 64'(fault_prob);
      a0  = likelihood(mag, s0) * s1 * (64'd65536 - p);
      a1  = likelihood(mag, s1) * s0 * p;
      total = a0 + a1;
      v.underflow = (total == 0);
      if (total == 0) begin
         post = p;
      end else begin
         q   = (a1 >= total) ? 64'd1 : 64'd0;
         rem = a1 - (q != 0 ? total : 64'd0);
         for (int i = 0; i < 17; i++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= total) begin
               rem = rem - total;
               q   = q | 64'd1;
            end
         end
         post = (q + 1) >> 1;
         if (post > 65535) post = 65535;
         fault_prob = post[15:0];
      end
      v.posterior = post[15:0];
      v.fault     = (post >= 64'(thresh_val));
      return v;
   endfunction

   task automatic report(string field, logic [15:0] got, logic [15:0] want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, field, got, want);
      mismatches++;
   endtask

   // result side: values are stable from the falling edge to the accepting edge
   always @(negedge clock) begin
      verdict_type w;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_verdicts.size() == 0) begin
            report("unexpected item", rsp.posterior, 16'd0);
         end else begin
            w = expected_verdicts.pop_front();
            if (rsp.posterior !== w.posterior)
               report("posterior", rsp.posterior, w.posterior);
            if (rsp.evidence_underflow !== w.underflow)
               report("evidence_underflow", 16'(rsp.evidence_underflow), 16'(w.underflow));
            if (rsp.fault_detected !== w.fault)
               report("fault_detected", 16'(rsp.fault_detected), 16'(w.fault));
         end
      end
   end

   // receiver stall pattern, plus a long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready  <= 1'b0;
         hold_left  <= 0;
         stall_mode <= 0;
         mode_left  <= 100;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(20, 600);
         end else begin
            mode_left <= mode_left - 1;
         end
         if (hold_kick) hold_left <= LONG_HOLD;
         else if (hold_left != 0) hold_left <= hold_left - 1;
         if (hold_kick || hold_left != 0)
            rsp.ready <= 1'b0;
         else case (stall_mode)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= ($urandom_range(0, 1) == 1);
            2: rsp.ready <= ($urandom_range(0, 9) == 0);
            default: rsp.ready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   task automatic csr_write(reg_index_type idx, logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx) << 2;
      csr_pwdata  <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_NORMAL_SIGMA:    sig_normal = value;
         REG_FAULT_SIGMA:     sig_fault  = value;
         REG_PRIOR_FAULT: begin
            prior_val  = value;
            fault_prob = value;
         end
         REG_FAULT_THRESHOLD: thresh_val = value;
      endcase
      @(posedge clock);
   endtask

   // drop valid and hold until every expected item has come back
   task automatic drain;
      req.valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // offer one measurement and predict once it is taken; returns the verdict
   task automatic send_measurement(logic signed [15:0] m, output verdict_type v);
      req.valid       <= 1'b1;
      req.measurement <= m;
      do @(negedge clock); while (!req.ready);
      @(posedge clock);
      v = bayes_update(m);
   endtask

   int burst_left;

   task automatic send_with_gaps(logic signed [15:0] m);
      verdict_type v;
      send_measurement(m, v);
      expected_verdicts.push_back(v);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if ($urandom_range(0, 3) != 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   function automatic dir_row_type blank_row();
      dir_row_type r;
      r.is_csr         = 1'b0;
      r.idx            = REG_NORMAL_SIGMA;
      r.value          = '0;
      r.typed          = 1'b0;
      r.want.posterior = '0;
      r.want.underflow = 1'b0;
      r.want.fault     = 1'b0;
      return r;
   endfunction

   function automatic void add_item(logic [15:0] m);
      dir_row_type r;
      r = blank_row();
      r.value = m;
      dir_table.push_back(r);
   endfunction

   function automatic void add_typed(logic [15:0] m, logic [15:0] post, bit uf, bit fd);
      dir_row_type r;
      r = blank_row();
      r.value = m;
      r.typed = 1'b1;
      r.want  = '{posterior: post, underflow: uf, fault: fd};
      dir_table.push_back(r);
   endfunction

   function automatic void add_csr(reg_index_type idx, logic [15:0] value);
      dir_row_type r;
      r = blank_row();
      r.is_csr = 1'b1;
      r.idx    = idx;
      r.value  = value;
      dir_table.push_back(r);
   endfunction

   function automatic logic signed [15:0] pick_measurement();
      int span;
      logic signed [15:0] m;
      span = 4 * int'(sig_fault == 0 ? 16'd1 : sig_fault);
      if (span > 32767) span = 32767;
      if ($urandom_range(0, 9) < 7) begin
         m = 16'($urandom_range(0, span));
         if ($urandom_range(0, 1) == 1) m = -m;
      end else begin
         m = 16'($urandom());
      end
      return m;
   endfunction

   initial begin
      verdict_type v;
      dir_row_type r;
      logic [15:0] ns;
      mismatches  = 0;
      burst_left  = 0;
      cycles      = 0;
      hold_kick   = 1'b0;
      reset       <= 1'b1;
      req.valid   <= 1'b0;
      req.measurement <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      sig_normal  = NORMAL_SIGMA_RST;
      sig_fault   = FAULT_SIGMA_RST;
      prior_val   = PRIOR_FAULT_RST;
      thresh_val  = FAULT_THRESHOLD_RST;
      fault_prob  = PRIOR_FAULT_RST;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes underflow both likelihoods: probability kept, flagged
      add_typed(16'h8000, PRIOR_FAULT_RST, 1'b1, 1'b0);
      add_typed(16'h7FFF, PRIOR_FAULT_RST, 1'b1, 1'b0);
      add_item(16'h0000);
      add_item(16'h0001);
      add_item(16'hFFFF);
      add_item(16'h0100);
      add_item(16'hFF00);
      add_item(16'h0C00);
      add_csr(REG_PRIOR_FAULT, 16'hFFFF);
      add_item(16'h0000);
      add_item(16'h0500);
      add_csr(REG_PRIOR_FAULT, 16'h0000);
      add_item(16'h0300);
      add_csr(REG_FAULT_THRESHOLD, 16'h0000);
      add_typed(16'h8000, 16'h0000, 1'b1, 1'b1);
      add_csr(REG_NORMAL_SIGMA, 16'h0000);
      add_csr(REG_FAULT_SIGMA, 16'h0000);
      add_csr(REG_PRIOR_FAULT, 16'h8000);
      add_item(16'h0000);
      add_item(16'h0001);
      add_csr(REG_NORMAL_SIGMA, 16'hFFFF);
      add_csr(REG_FAULT_SIGMA, 16'hFFFF);
      add_csr(REG_FAULT_THRESHOLD, 16'hFFFF);
      add_item(16'h8000);
      add_item(16'h7FFF);
      add_csr(REG_NORMAL_SIGMA, 16'h0100);
      add_csr(REG_FAULT_SIGMA, 16'h2000);
      add_csr(REG_PRIOR_FAULT, 16'hF000);
      add_item(16'h1800);
      add_item(16'hE800);

      foreach (dir_table[i]) begin
         r = dir_table[i];
         if (r.is_csr) begin
            drain();
            csr_write(r.idx, r.value);
         end else begin
            send_measurement(r.value, v);
            expected_verdicts.push_back(r.typed ? r.want : v);
         end
      end

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         // pause until all items are back, then reprogram
         drain();
         case (ph)
            0: ns = 16'd1;
            1: ns = 16'hFFFF;
            2: ns = 16'd0;
            default: ns = 16'($urandom_range(32, 1024));
         endcase
         csr_write(REG_NORMAL_SIGMA, ns);
         csr_write(REG_FAULT_SIGMA, (ph == 1) ? 16'd1 :
                   16'($urandom_range(int'(ns == 0 ? 16'd1 : ns), 8192)));
         csr_write(REG_FAULT_THRESHOLD, (ph == 2) ? 16'hFFFF : 16'($urandom()));
         csr_write(REG_PRIOR_FAULT, 16'($urandom_range(1, 65535)));
         if (ph == 3) begin
            hold_kick <= 1'b1;
            @(posedge clock);
            hold_kick <= 1'b0;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // re-arm the prior now and then so the posterior does not pin
            if ($urandom_range(0, 40) == 0) begin
               drain();
               csr_write(REG_PRIOR_FAULT, 16'($urandom()));
            end
            send_with_gaps(pick_measurement());
         end
      end

      drain();
      repeat (200) @(posedge clock);
      if (mismatches == 0 && expected_verdicts.size() == 0)
         $display("tb_bayesian_sensor_fault_detector passed");
      else
         $display("tb_bayesian_sensor_fault_detector failed");
      $finish;
   end

endmodule
